>>> design/krq_pkg.sv
package krq_pkg;

    localparam int NUM_KEYS_DEFAULT    = 4;
    localparam int QUEUE_DEPTH_DEFAULT = 3;

    localparam int ID_REGS     = 4;
    localparam int ID_SEL_W    = $clog2(ID_REGS);
    localparam int KEY_LEVEL_W = 4;
    localparam int KEY_ID_W    = 8;
    localparam int TIME_W      = 32;
    localparam int MIN_PRESS_W = 16;
    localparam int KEY_COUNT_W = 3;
    localparam int PEND_W      = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [MIN_PRESS_W-1:0] MIN_PRESS_RESET = 16'd50;

    localparam logic FUNC_SCAN = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_COUNT = 3'd0,
        REG_KEY_ID_0  = 3'd1,
        REG_KEY_ID_1  = 3'd2,
        REG_KEY_ID_2  = 3'd3,
        REG_KEY_ID_3  = 3'd4,
        REG_MIN_PRESS = 3'd5
    } cfg_reg_t;

    typedef logic [ID_REGS-1:0][KEY_ID_W-1:0] key_id_array_t;

    typedef struct packed {
        logic                   func;
        logic [KEY_LEVEL_W-1:0] key_levels;
        logic [TIME_W-1:0]      now_ms;
    } cmd_word_t;

    typedef struct packed {
        logic                event_valid;
        logic [KEY_ID_W-1:0] event_key_id;
        logic [PEND_W-1:0]   pending_count;
    } result_word_t;

    typedef struct packed {
        logic load;
        logic pop;
    } merge_ctrl_t;

endpackage

>>> design/krq_lane.sv
module krq_lane (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic                             step,
    input  logic                             level,
    input  logic [krq_pkg::TIME_W-1:0]       now_ms,
    input  logic [krq_pkg::MIN_PRESS_W-1:0]  min_press_ms,
    output logic                             qualify
);

    localparam int TIME_W = krq_pkg::TIME_W;

    logic              pressed_reg;
    logic              pressed_next;
    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] start_next;
    logic              qual_reg;
    logic              qual_next;
    logic [TIME_W-1:0] held;

    assign held = now_ms - start_reg;

    always_comb
    begin
        pressed_next = pressed_reg;
        start_next   = start_reg;
        qual_next    = 1'b0;
        if (step)
        begin
            if (!level && !pressed_reg)
            begin
                pressed_next = 1'b1;
                start_next   = now_ms;
            end
            else if (level && pressed_reg)
            begin
                pressed_next = 1'b0;
                qual_next    = (held >= TIME_W'(min_press_ms));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg <= 1'b0;
            qual_reg    <= 1'b0;
        end
        else
        begin
            pressed_reg <= pressed_next;
            if (accept)
            begin
                qual_reg <= qual_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
    end

    assign qualify = qual_reg;

`ifndef SYNTHESIS
    // The pressed flag moves only on a scan that covers this key.
    a_pressed_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(pressed_reg))
        else $error("key flag changed without a scan");
`endif

endmodule

>>> design/krq_merge.sv
module krq_merge #(
    parameter int LANES       = krq_pkg::NUM_KEYS_DEFAULT,
    parameter int QUEUE_DEPTH = krq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  krq_pkg::merge_ctrl_t   ctrl,
    input  logic [LANES-1:0]       qualify,
    input  krq_pkg::key_id_array_t key_id,
    input  logic                   evt_ready,
    output logic                   evt_valid,
    output krq_pkg::result_word_t  evt_word
);

    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int PW     = CW + 2;
    localparam int ID_W   = krq_pkg::KEY_ID_W;
    localparam int PEND_W = krq_pkg::PEND_W;

    logic [ID_W-1:0]       queue_reg  [QUEUE_DEPTH];
    logic [ID_W-1:0]       queue_next [QUEUE_DEPTH];
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [PW-1:0]         pos [LANES];
    logic [PW-1:0]         acc;
    logic                  evt_valid_reg;
    krq_pkg::result_word_t evt_word_reg;
    krq_pkg::result_word_t result;

    always_comb
    begin
        acc = PW'(count_reg);
        for (int i = 0; i < LANES; i++)
        begin
            pos[i] = acc;
            acc    = acc + PW'(qualify[i]);
        end
    end

    always_comb
    begin
        for (int e = 0; e < QUEUE_DEPTH; e++)
        begin
            queue_next[e] = queue_reg[e];
        end
        count_next           = count_reg;
        result.event_valid   = 1'b0;
        result.event_key_id  = '0;
        if (ctrl.pop)
        begin
            if (count_reg != '0)
            begin
                result.event_valid  = 1'b1;
                result.event_key_id = queue_reg[0];
                for (int e = 0; e < QUEUE_DEPTH - 1; e++)
                begin
                    queue_next[e] = queue_reg[e + 1];
                end
                count_next = count_reg - 1'b1;
            end
        end
        else
        begin
            for (int e = 0; e < QUEUE_DEPTH; e++)
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    if (qualify[i] && pos[i] == PW'(e))
                    begin
                        queue_next[e] = key_id[i];
                    end
                end
            end
            count_next = (acc > PW'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : CW'(acc);
        end
        result.pending_count = PEND_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.load)
            begin
                count_reg     <= count_next;
                evt_valid_reg <= 1'b1;
            end
            else if (evt_ready)
            begin
                evt_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            for (int e = 0; e < QUEUE_DEPTH; e++)
            begin
                queue_reg[e] <= queue_next[e];
            end
            evt_word_reg <= result;
        end
    end

    assign evt_valid = evt_valid_reg;
    assign evt_word  = evt_word_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_scan_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load && !ctrl.pop |=> !evt_word_reg.event_valid)
        else $error("scan word reported an event");

    a_pop_takes_one: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load && ctrl.pop && count_reg != '0
        |=> evt_word_reg.event_valid && count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not remove exactly one event");
`endif

endmodule

>>> design/key_release_event_queue_unit.sv
// Channel  Handshake               Word
// cmd      cmd_valid / cmd_ready   cmd_word  (func, key_levels, now_ms)
// evt      evt_valid / evt_ready   evt_word  (event_valid, event_key_id, pending_count)
// cfg      cfg_wr_en               cfg_index, cfg_wdata
//
// One word is accepted each cycle cmd_ready is high; its result is registered in evt_word.
// The key lanes compare hold times in the first stage and the queue merge runs in the second.
// Reset is asynchronous and active low; there is no clearing pass after reset.
// A stalled result holds the output register, and one more word may enter behind it.
module key_release_event_queue_unit #(
    parameter int NUM_KEYS    = krq_pkg::NUM_KEYS_DEFAULT,
    parameter int QUEUE_DEPTH = krq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  krq_pkg::cmd_word_t               cmd_word,
    output logic                             evt_valid,
    input  logic                             evt_ready,
    output krq_pkg::result_word_t            evt_word,
    input  logic                             cfg_wr_en,
    input  logic [krq_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [krq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int LANES    = (NUM_KEYS < krq_pkg::ID_REGS) ? NUM_KEYS : krq_pkg::ID_REGS;
    localparam int KC_W     = krq_pkg::KEY_COUNT_W;
    localparam int ID_W     = krq_pkg::KEY_ID_W;
    localparam int ID_SEL_W = krq_pkg::ID_SEL_W;
    localparam int MP_W     = krq_pkg::MIN_PRESS_W;
    localparam int IDX_W    = krq_pkg::CFG_INDEX_W;

    logic [KC_W-1:0]        key_count_reg;
    krq_pkg::key_id_array_t key_id_reg;
    logic [MP_W-1:0]        min_press_reg;
    logic [ID_SEL_W-1:0]    id_slot;

    logic                   s1_valid_reg;
    logic                   s1_pop_reg;
    logic                   accept;
    logic                   load;
    logic                   scan;
    logic [LANES-1:0]       qualify;
    krq_pkg::merge_ctrl_t   ctrl;

    assign id_slot = ID_SEL_W'(cfg_index - IDX_W'(krq_pkg::REG_KEY_ID_0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= '0;
            key_id_reg    <= '0;
            min_press_reg <= krq_pkg::MIN_PRESS_RESET;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == krq_pkg::REG_KEY_COUNT)
            begin
                key_count_reg <= KC_W'(cfg_wdata);
            end
            else if (cfg_index >= krq_pkg::REG_KEY_ID_0 && cfg_index <= krq_pkg::REG_KEY_ID_3)
            begin
                key_id_reg[id_slot] <= ID_W'(cfg_wdata);
            end
            else if (cfg_index == krq_pkg::REG_MIN_PRESS)
            begin
                min_press_reg <= MP_W'(cfg_wdata);
            end
        end
    end

    assign load      = s1_valid_reg && (!evt_valid || evt_ready);
    assign cmd_ready = !s1_valid_reg || load;
    assign accept    = cmd_valid && cmd_ready;
    assign scan      = accept && (cmd_word.func == krq_pkg::FUNC_SCAN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (load)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pop_reg <= (cmd_word.func == krq_pkg::FUNC_POP);
        end
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        krq_lane u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .accept       (accept),
            .step         (scan && (key_count_reg > KC_W'(i))),
            .level        (cmd_word.key_levels[i]),
            .now_ms       (cmd_word.now_ms),
            .min_press_ms (min_press_reg),
            .qualify      (qualify[i])
        );
    end

    assign ctrl.load = load;
    assign ctrl.pop  = s1_pop_reg;

    krq_merge #(
        .LANES       (LANES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .qualify   (qualify),
        .key_id    (key_id_reg),
        .evt_ready (evt_ready),
        .evt_valid (evt_valid),
        .evt_word  (evt_word)
    );

endmodule
